[sv/atfb_pkg.sv]
package atfb_pkg;

   localparam int MAX_PAYLOAD = 256;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 9;
   localparam int TOTAL_W = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W = 5;

   localparam logic [BYTE_W-1:0] START_DELIM = 8'h7E;
   localparam logic [BYTE_W-1:0] FRAME_TYPE_TX = 8'h10;
   localparam logic [BYTE_W-1:0] CHECKSUM_BASE = 8'hFF;
   localparam logic [TOTAL_W-1:0] LEN_OVERHEAD = 16'd14;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ID = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_LONG = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_SHORT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX_OPTIONS = 3'd4;

   localparam logic [7:0] RST_FRAME_ID = 8'h01;
   localparam logic [63:0] RST_DEST_LONG = 64'h0;
   localparam logic [15:0] RST_DEST_SHORT = 16'hFFFE;
   localparam logic [7:0] RST_HOP_RADIUS = 8'h00;
   localparam logic [7:0] RST_TX_OPTIONS = 8'h00;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [63:0] dest_address_long;
      logic [15:0] dest_address_short;
      logic [7:0] hop_radius;
      logic [7:0] tx_options;
   } cfg_type;

   // One classified input item, as handed from the front to the back.
   typedef struct packed {
      logic start;
      logic has_byte;
      logic ends_frame;
      logic [BYTE_W-1:0] data;
      logic [TOTAL_W-1:0] total;
   } cmd_type;

endpackage

[sv/atfb_if.sv]
interface atfb_req_if;
   import atfb_pkg::*;

   logic valid;
   logic ready;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0] payload_length;

   modport source (output valid, output payload_byte, output payload_length, input ready);
   modport sink (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface atfb_rsp_if;
   import atfb_pkg::*;

   logic valid;
   logic ready;
   logic [BYTE_W-1:0] tx_byte;
   logic last_of_run;
   logic frame_end;

   modport source (output valid, output tx_byte, output last_of_run, output frame_end,
                   input ready);
   modport sink (input valid, input tx_byte, input last_of_run, input frame_end,
                 output ready);
endinterface

[sv/atfb_front.sv]
module atfb_front (
   input  logic clock,
   input  logic reset,
   atfb_req_if.sink req_chan,
   input  logic q_full,
   output logic q_push,
   output atfb_pkg::cmd_type q_cmd
);
   import atfb_pkg::*;

   logic in_frame_ff, in_frame_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] plen_sat;
   logic accept;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;
   assign q_push = accept;

   always_comb begin
      if (32'(req_chan.payload_length) > MAX_PAYLOAD) begin
         plen_sat = LEN_W'(MAX_PAYLOAD);
      end else begin
         plen_sat = req_chan.payload_length;
      end
   end

   always_comb begin
      q_cmd.data = req_chan.payload_byte;
      q_cmd.total = TOTAL_W'(plen_sat) + LEN_OVERHEAD;
      in_frame_in = in_frame_ff;
      remain_in = remain_ff;
      if (!in_frame_ff) begin
         // A frame opens: the header goes out, plus the first byte if there is one.
         q_cmd.start = 1'b1;
         q_cmd.has_byte = (plen_sat != '0);
         q_cmd.ends_frame = (plen_sat <= LEN_W'(1));
         if (accept) begin
            in_frame_in = (plen_sat > LEN_W'(1));
            remain_in = plen_sat - LEN_W'(1);
         end
      end else begin
         q_cmd.start = 1'b0;
         q_cmd.has_byte = 1'b1;
         q_cmd.ends_frame = (remain_ff <= LEN_W'(1));
         if (accept) begin
            in_frame_in = (remain_ff > LEN_W'(1));
            remain_in = remain_ff - LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         remain_ff <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         remain_ff <= remain_in;
      end
   end

endmodule

[sv/atfb_queue.sv]
module atfb_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  atfb_pkg::cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output logic empty,
   output atfb_pkg::cmd_type head_cmd
);
   import atfb_pkg::*;

   cmd_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/atfb_back.sv]
module atfb_back (
   input  logic clock,
   input  logic reset,
   input  atfb_pkg::cfg_type cfg,
   input  logic q_empty,
   input  atfb_pkg::cmd_type head_cmd,
   output logic q_pop,
   atfb_rsp_if.source rsp_chan
);
   import atfb_pkg::*;

   localparam logic [STEP_W-1:0] STEP_DELIM = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LEN_HI = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LEN_LO = 5'd2;
   localparam logic [STEP_W-1:0] STEP_TYPE = 5'd3;
   localparam logic [STEP_W-1:0] STEP_FRAME_ID = 5'd4;
   localparam logic [STEP_W-1:0] STEP_LONG_LAST = 5'd12;
   localparam logic [STEP_W-1:0] STEP_SHORT_HI = 5'd13;
   localparam logic [STEP_W-1:0] STEP_SHORT_LO = 5'd14;
   localparam logic [STEP_W-1:0] STEP_RADIUS = 5'd15;
   localparam logic [STEP_W-1:0] STEP_OPTIONS = 5'd16;
   localparam logic [STEP_W-1:0] STEP_PAYLOAD = 5'd17;
   localparam logic [STEP_W-1:0] STEP_CHECKSUM = 5'd18;

   logic busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic out_last_ff, out_last_in;
   logic out_end_ff, out_end_in;

   logic [STEP_W-1:0] first_step, cur_step, next_step;
   logic [2:0] long_idx;
   logic [BYTE_W-1:0] cur_byte;
   logic summed, done, fire;

   assign fire = !q_empty && (!out_valid_ff || rsp_chan.ready);
   assign q_pop = fire && done;

   always_comb begin
      if (head_cmd.start) begin
         first_step = STEP_DELIM;
      end else if (head_cmd.has_byte) begin
         first_step = STEP_PAYLOAD;
      end else begin
         first_step = STEP_CHECKSUM;
      end
      cur_step = busy_ff ? step_ff : first_step;
      long_idx = 3'(STEP_LONG_LAST - cur_step);
   end

   // Work out what follows the current byte within this transaction.
   always_comb begin
      done = 1'b0;
      next_step = cur_step + STEP_W'(1);
      if (cur_step == STEP_OPTIONS) begin
         if (head_cmd.has_byte) begin
            next_step = STEP_PAYLOAD;
         end else begin
            next_step = STEP_CHECKSUM;
         end
      end else if (cur_step == STEP_PAYLOAD) begin
         next_step = STEP_CHECKSUM;
         done = !head_cmd.ends_frame;
      end else if (cur_step >= STEP_CHECKSUM) begin
         done = 1'b1;
      end
   end

   always_comb begin
      summed = 1'b1;
      unique case (cur_step)
         STEP_DELIM: begin
            cur_byte = START_DELIM;
            summed = 1'b0;
         end
         STEP_LEN_HI: begin
            cur_byte = head_cmd.total[15:8];
            summed = 1'b0;
         end
         STEP_LEN_LO: begin
            cur_byte = head_cmd.total[7:0];
            summed = 1'b0;
         end
         STEP_TYPE: cur_byte = FRAME_TYPE_TX;
         STEP_FRAME_ID: cur_byte = cfg.frame_id;
         STEP_SHORT_HI: cur_byte = cfg.dest_address_short[15:8];
         STEP_SHORT_LO: cur_byte = cfg.dest_address_short[7:0];
         STEP_RADIUS: cur_byte = cfg.hop_radius;
         STEP_OPTIONS: cur_byte = cfg.tx_options;
         STEP_PAYLOAD: cur_byte = head_cmd.data;
         STEP_CHECKSUM: begin
            cur_byte = CHECKSUM_BASE - sum_ff;
            summed = 1'b0;
         end
         default: cur_byte = BYTE_W'(cfg.dest_address_long >> {long_idx, 3'b000});
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      sum_in = sum_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_end_in = out_end_ff;
      if (fire) begin
         busy_in = !done;
         step_in = next_step;
         if (cur_step == STEP_DELIM) begin
            sum_in = '0;
         end else if (summed) begin
            sum_in = sum_ff + cur_byte;
         end
         out_valid_in = 1'b1;
         out_byte_in = cur_byte;
         out_last_in = done;
         out_end_in = (cur_step == STEP_CHECKSUM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         sum_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         sum_ff <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff <= out_end_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.tx_byte = out_byte_ff;
   assign rsp_chan.last_of_run = out_last_ff;
   assign rsp_chan.frame_end = out_end_ff;

endmodule

[sv/api_transmit_frame_builder.sv]
// The first byte of a transaction passes through the command queue and the output
// register before it can be taken from rsp_chan. A payload transaction inside a frame
// gives one byte per cycle while rsp_chan takes every byte; a frame start sends the header,
// then the first payload byte if there is one, and the checksum if the frame ends there.
// The two-entry command queue lets the input keep flowing while the sequencer works.
// Reset is synchronous and active high; it empties the queue and output register, ends
// any open frame and loads the configuration registers with their default values.
module api_transmit_frame_builder (
   input  logic clock,
   input  logic reset,
   atfb_req_if.sink req_chan,
   atfb_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic [atfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [atfb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import atfb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, head_cmd;
   logic q_push, q_full, q_pop, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_ID: cfg_in.frame_id = csr_wdata[7:0];
            CSR_DEST_LONG: cfg_in.dest_address_long = csr_wdata;
            CSR_DEST_SHORT: cfg_in.dest_address_short = csr_wdata[15:0];
            CSR_HOP_RADIUS: cfg_in.hop_radius = csr_wdata[7:0];
            CSR_TX_OPTIONS: cfg_in.tx_options = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_id <= RST_FRAME_ID;
         cfg_ff.dest_address_long <= RST_DEST_LONG;
         cfg_ff.dest_address_short <= RST_DEST_SHORT;
         cfg_ff.hop_radius <= RST_HOP_RADIUS;
         cfg_ff.tx_options <= RST_TX_OPTIONS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atfb_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(push_cmd)
   );

   atfb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(push_cmd),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .head_cmd(head_cmd)
   );

   atfb_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .head_cmd(head_cmd),
      .q_pop(q_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

[sv/atfb_checker.sv]
module atfb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic rsp_last_of_run,
   input logic rsp_frame_end
);

   // The checksum always closes the run of bytes for its transaction.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last_of_run)
      else $error("frame_end without last_of_run");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

   // With the queue empty after reset, the input side must be open.
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready)
      else $error("input not ready after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
         && $stable(rsp_last_of_run) && $stable(rsp_frame_end))
      else $error("stalled output changed");

   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$isunknown(rsp_valid))
      else $error("output valid unknown after a transaction");

endmodule

bind api_transmit_frame_builder atfb_checker u_atfb_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_tx_byte(rsp_chan.tx_byte),
   .rsp_last_of_run(rsp_chan.last_of_run),
   .rsp_frame_end(rsp_chan.frame_end)
);
